// ----- rtl/lbec_pkg.sv -----
// Shared types, phase codes and timing constants for the LED error-code signaler.
package lbec_pkg;

    // Request kinds carried in tuser
    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_START = 1'b1;

    // Pattern phases
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_PRE   = 3'd1;
    localparam logic [2:0] PH_MARK  = 3'd2;
    localparam logic [2:0] PH_SPACE = 3'd3;
    localparam logic [2:0] PH_PHI   = 3'd4;
    localparam logic [2:0] PH_PLO   = 3'd5;

    // Phase lengths in tenths of a beat
    localparam logic [6:0] LEN_PRE   = 7'd80;
    localparam logic [6:0] LEN_MARK  = 7'd100;
    localparam logic [6:0] LEN_SPACE = 7'd70;
    localparam logic [6:0] LEN_PHI   = 7'd4;
    localparam logic [6:0] LEN_PLO   = 7'd16;

    // Code saturation and decimal split constants
    localparam logic [31:0] CODE_MAX   = 32'd999;
    localparam logic [15:0] HUND_RECIP = 16'd41;   // n/100 == (n*41)>>12 for n < 1000
    localparam logic [15:0] HUND       = 16'd100;
    localparam logic [14:0] TEN_RECIP  = 15'd205;  // n/10 == (n*205)>>11 for n < 100
    localparam logic [7:0]  TEN        = 8'd10;
    localparam logic [3:0]  DIGIT_MAX  = 4'd9;
    localparam logic [1:0]  LAST_DIGIT = 2'd2;

    // Item after the first split step: hundreds digit and remainder below 100
    typedef struct packed {
        logic       valid;
        logic       req;
        logic [3:0] hund;
        logic [6:0] rem;
    } t_split_item;

    // One result item
    typedef struct packed {
        logic signaling;
        logic led_on;
    } t_result;

endpackage

// ----- rtl/lbec_digit_split.sv -----
// Input register with code saturation, then the hundreds split stage.
module lbec_digit_split (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic                  i_req,
    input  logic [31:0]           i_code,
    output lbec_pkg::t_split_item o_item
);

    logic                  r_valid;
    logic                  r_req;
    logic [9:0]            r_code;
    logic [9:0]            n_code;
    lbec_pkg::t_split_item r_item;
    logic [15:0]           w_prod;
    logic [3:0]            w_hund;
    logic [15:0]           w_hund_x100;
    logic [9:0]            w_rem;

    // Saturate to 999 ahead of the input register
    assign n_code = (i_code > lbec_pkg::CODE_MAX) ? lbec_pkg::CODE_MAX[9:0] : i_code[9:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_req  <= i_req;
            r_code <= n_code;
        end
    end

    // Hundreds digit by reciprocal multiply, remainder by subtract
    assign w_prod      = 16'(r_code) * lbec_pkg::HUND_RECIP;
    assign w_hund      = w_prod[15:12];
    assign w_hund_x100 = 16'(w_hund) * lbec_pkg::HUND;
    assign w_rem       = r_code - w_hund_x100[9:0];

    // Split register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.valid <= 1'b0;
        end else if (i_en) begin
            r_item.valid <= r_valid;
            r_item.req   <= r_req;
            r_item.hund  <= w_hund;
            r_item.rem   <= w_rem[6:0];
        end
    end

    assign o_item = r_item;

endmodule

// ----- rtl/lbec_seq.sv -----
// Blink pattern sequencer: pattern state, prescaler and phase timing.
module lbec_seq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  lbec_pkg::t_split_item i_item,
    input  logic [15:0]           i_ticks_per_tenth,
    output logic                  o_push,
    output lbec_pkg::t_result     o_result
);

    logic        r_active, n_active;
    logic [3:0]  r_dig [3];
    logic [3:0]  n_dig [3];
    logic [2:0]  r_phase, n_phase;
    logic [1:0]  r_didx, n_didx;
    logic [3:0]  r_pulses, n_pulses;
    logic [6:0]  r_dur, n_dur;
    logic [15:0] r_presc, n_presc;

    logic [14:0] w_tens_prod;
    logic [3:0]  w_tens;
    logic [7:0]  w_tens_x10;
    logic [6:0]  w_units;
    logic [15:0] w_limit;
    logic [15:0] w_presc_inc;
    logic        w_roll;
    logic [6:0]  w_dur_dec;
    logic [3:0]  w_pulses_dec;
    logic [1:0]  w_next_idx;
    logic [3:0]  w_sel_dig;
    logic [3:0]  w_sel_clamped;
    logic        w_do;

    // Tens and units from the remainder below 100
    assign w_tens_prod = 15'(i_item.rem) * lbec_pkg::TEN_RECIP;
    assign w_tens      = w_tens_prod[14:11];
    assign w_tens_x10  = 8'(w_tens) * lbec_pkg::TEN;
    assign w_units     = i_item.rem - w_tens_x10[6:0];

    // Prescaler rollover; a zero setting counts as one
    assign w_limit     = (i_ticks_per_tenth == 16'd0) ? 16'd1 : i_ticks_per_tenth;
    assign w_presc_inc = r_presc + 16'd1;
    assign w_roll      = (w_presc_inc >= w_limit) || (w_presc_inc == 16'd0);
    assign w_dur_dec   = (r_dur != 7'd0) ? r_dur - 7'd1 : r_dur;
    assign w_pulses_dec = (r_pulses != 4'd0) ? r_pulses - 4'd1 : r_pulses;

    // Next digit index: first nonzero after the mark, else units; otherwise the following one
    always_comb begin
        if (r_phase == lbec_pkg::PH_MARK) begin
            if (r_dig[0] != 4'd0) begin
                w_next_idx = 2'd0;
            end else if (r_dig[1] != 4'd0) begin
                w_next_idx = 2'd1;
            end else begin
                w_next_idx = lbec_pkg::LAST_DIGIT;
            end
        end else begin
            w_next_idx = r_didx + 2'd1;
        end
    end

    // Digit read and clamp to 1..9
    always_comb begin
        case (w_next_idx)
            2'd0:    w_sel_dig = r_dig[0];
            2'd1:    w_sel_dig = r_dig[1];
            default: w_sel_dig = r_dig[2];
        endcase
        if (w_sel_dig == 4'd0) begin
            w_sel_clamped = 4'd1;
        end else if (w_sel_dig > lbec_pkg::DIGIT_MAX) begin
            w_sel_clamped = lbec_pkg::DIGIT_MAX;
        end else begin
            w_sel_clamped = w_sel_dig;
        end
    end

    assign w_do = i_item.valid && i_en;

    // Next state for one item
    always_comb begin
        n_active = r_active;
        n_dig    = r_dig;
        n_phase  = r_phase;
        n_didx   = r_didx;
        n_pulses = r_pulses;
        n_dur    = r_dur;
        n_presc  = r_presc;
        if (w_do) begin
            if (i_item.req == lbec_pkg::REQ_START) begin
                if (!r_active) begin
                    n_active = 1'b1;
                    n_dig[0] = i_item.hund;
                    n_dig[1] = w_tens;
                    n_dig[2] = w_units[3:0];
                    n_phase  = lbec_pkg::PH_PRE;
                    n_dur    = lbec_pkg::LEN_PRE;
                    n_presc  = 16'd0;
                    n_didx   = 2'd0;
                    n_pulses = 4'd0;
                end
            end else if (r_active) begin
                if (!w_roll) begin
                    n_presc = w_presc_inc;
                end else begin
                    n_presc = 16'd0;
                    n_dur   = w_dur_dec;
                    if (w_dur_dec == 7'd0) begin
                        unique case (r_phase)
                            lbec_pkg::PH_PRE: begin
                                n_phase = lbec_pkg::PH_MARK;
                                n_dur   = lbec_pkg::LEN_MARK;
                            end
                            lbec_pkg::PH_MARK: begin
                                n_didx   = w_next_idx;
                                n_pulses = w_sel_clamped;
                                n_phase  = lbec_pkg::PH_SPACE;
                                n_dur    = lbec_pkg::LEN_SPACE;
                            end
                            lbec_pkg::PH_SPACE: begin
                                n_phase = lbec_pkg::PH_PHI;
                                n_dur   = lbec_pkg::LEN_PHI;
                            end
                            lbec_pkg::PH_PHI: begin
                                n_phase = lbec_pkg::PH_PLO;
                                n_dur   = lbec_pkg::LEN_PLO;
                            end
                            lbec_pkg::PH_PLO: begin
                                n_pulses = w_pulses_dec;
                                if (w_pulses_dec != 4'd0) begin
                                    n_phase = lbec_pkg::PH_PHI;
                                    n_dur   = lbec_pkg::LEN_PHI;
                                end else if (r_didx < lbec_pkg::LAST_DIGIT) begin
                                    n_didx   = w_next_idx;
                                    n_pulses = w_sel_clamped;
                                    n_phase  = lbec_pkg::PH_SPACE;
                                    n_dur    = lbec_pkg::LEN_SPACE;
                                end else begin
                                    n_phase = lbec_pkg::PH_PRE;
                                    n_dur   = lbec_pkg::LEN_PRE;
                                end
                            end
                            default: begin
                                n_phase = lbec_pkg::PH_PRE;
                                n_dur   = lbec_pkg::LEN_PRE;
                            end
                        endcase
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_dig[0] <= 4'd0;
            r_dig[1] <= 4'd0;
            r_dig[2] <= 4'd0;
            r_phase  <= lbec_pkg::PH_IDLE;
            r_didx   <= 2'd0;
            r_pulses <= 4'd0;
            r_dur    <= 7'd0;
            r_presc  <= 16'd0;
        end else begin
            r_active <= n_active;
            r_dig    <= n_dig;
            r_phase  <= n_phase;
            r_didx   <= n_didx;
            r_pulses <= n_pulses;
            r_dur    <= n_dur;
            r_presc  <= n_presc;
        end
    end

    // Result reflects the state after this item
    assign o_push             = w_do;
    assign o_result.signaling = n_active;
    assign o_result.led_on    = n_active &&
                                ((n_phase == lbec_pkg::PH_MARK) || (n_phase == lbec_pkg::PH_PHI));

endmodule

// ----- rtl/lbec_out_buf.sv -----
// Two-entry result buffer: output register plus skid entry.
module lbec_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  lbec_pkg::t_result i_data,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_ready,
    output lbec_pkg::t_result o_data
);

    logic [1:0]        r_cnt, n_cnt;
    lbec_pkg::t_result r_d0;
    lbec_pkg::t_result r_d1;
    logic              w_pop;

    assign w_pop = (r_cnt != 2'd0) && i_ready;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !w_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && w_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // Entry shuffle: head drains first, new transfer lands behind it
    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            if (r_cnt == 2'd2) begin
                r_d0 <= r_d1;
                if (i_push) begin
                    r_d1 <= i_data;
                end
            end else if (i_push) begin
                r_d0 <= i_data;
            end
        end else if (i_push) begin
            if (r_cnt == 2'd0) begin
                r_d0 <= i_data;
            end else begin
                r_d1 <= i_data;
            end
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_d0;

endmodule

// ----- rtl/led_blink_error_code_signaler.sv -----
// Top level of the LED blink error-code signaler.
//
//  Channel   Direction  Handshake                     Payload
//  s_axis    in         s_axis_tvalid/s_axis_tready   tuser: req_type; tdata: error_code
//  m_axis    out        m_axis_tvalid/m_axis_tready   tdata: led_on, signaling
//  cfg       in         i_cfg_valid/o_cfg_ready       i_cfg_data: ticks_per_tenth_beat
//
// One item per cycle while the buffer has room; a result passes the input register,
// the hundreds split register and the sequencer update into the result buffer.
// All stages advance together while the two-entry result buffer has room;
// a stalled m_axis drops s_axis_tready only once both entries hold results.
// Synchronous active-low reset clears the pattern state; the tick divider resets to 1.
module led_blink_error_code_signaler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] error_code
    input  logic [0:0]  s_axis_tuser,   // [0] req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [0] led_on, [1] signaling, [7:2] zero
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    logic [15:0]           r_tpt;
    logic                  w_en;
    logic                  w_full;
    logic                  w_push;
    lbec_pkg::t_split_item w_item;
    lbec_pkg::t_result     w_result;
    lbec_pkg::t_result     w_out;

    // Tick divider register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpt <= 16'd1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_tpt <= i_cfg_data;
        end
    end

    // Pipeline advance
    assign w_en          = !w_full;
    assign s_axis_tready = w_en;

    lbec_digit_split u_split (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (s_axis_tvalid),
        .i_req   (s_axis_tuser[0]),
        .i_code  (s_axis_tdata),
        .o_item  (w_item)
    );

    lbec_seq u_seq (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_en              (w_en),
        .i_item            (w_item),
        .i_ticks_per_tenth (r_tpt),
        .o_push            (w_push),
        .o_result          (w_result)
    );

    lbec_out_buf u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_result),
        .o_full  (w_full),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (w_out)
    );

    assign m_axis_tdata = {6'd0, w_out.signaling, w_out.led_on};

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking stream testbench for the LED blink error-code signaler.
module testbench;

    // DUT ports, all inputs known from time zero
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;    // [31:0] error_code
    logic [0:0]  s_axis_tuser  = '0;    // [0] req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;          // [0] led_on, [1] signaling, [7:2] zero
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data    = '0;

    led_blink_error_code_signaler dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    // Blink pattern predictor state
    logic        pat_active  = 1'b0;
    logic [3:0]  pat_digit [3] = '{4'd0, 4'd0, 4'd0};
    logic [2:0]  pat_phase   = lbec_pkg::PH_IDLE;
    logic [1:0]  pat_idx     = 2'd0;
    logic [3:0]  pat_pulses  = 4'd0;
    logic [6:0]  pat_tenths  = 7'd0;
    logic [15:0] pat_presc   = 16'd0;
    logic [15:0] tenth_div   = 16'd1;

    lbec_pkg::t_result led_expect_q [$];
    lbec_pkg::t_result led_exp;
    int                mismatch_count = 0;

    // Sender burst and receiver stall state
    int          burst_left = 0;
    int          rx_cnt     = 0;
    int          rx_mode    = 0;
    int          hold_req   = 0;
    int          hold_ack   = 0;
    int          hold_left  = 0;

    // Clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic [3:0] clamp_pulses(input logic [3:0] d);
        if (d < 4'd1) return 4'd1;
        if (d > lbec_pkg::DIGIT_MAX) return lbec_pkg::DIGIT_MAX;
        return d;
    endfunction

    function void open_digit(input logic [1:0] idx);
        pat_idx    = idx;
        pat_pulses = clamp_pulses(pat_digit[idx]);
        pat_phase  = lbec_pkg::PH_SPACE;
        pat_tenths = lbec_pkg::LEN_SPACE;
    endfunction

    // Phase sequencing at the end of a timed phase
    function void close_phase();
        case (pat_phase)
            lbec_pkg::PH_PRE: begin
                pat_phase  = lbec_pkg::PH_MARK;
                pat_tenths = lbec_pkg::LEN_MARK;
            end
            lbec_pkg::PH_MARK: begin
                // skip leading zero digits, units always sent
                if (pat_digit[0] != 0) open_digit(2'd0);
                else if (pat_digit[1] != 0) open_digit(2'd1);
                else open_digit(lbec_pkg::LAST_DIGIT);
            end
            lbec_pkg::PH_SPACE: begin
                pat_phase  = lbec_pkg::PH_PHI;
                pat_tenths = lbec_pkg::LEN_PHI;
            end
            lbec_pkg::PH_PHI: begin
                pat_phase  = lbec_pkg::PH_PLO;
                pat_tenths = lbec_pkg::LEN_PLO;
            end
            lbec_pkg::PH_PLO: begin
                if (pat_pulses > 0) pat_pulses = pat_pulses - 4'd1;
                if (pat_pulses != 0) begin
                    pat_phase  = lbec_pkg::PH_PHI;
                    pat_tenths = lbec_pkg::LEN_PHI;
                end else if (pat_idx < lbec_pkg::LAST_DIGIT) begin
                    open_digit(pat_idx + 2'd1);
                end else begin
                    pat_phase  = lbec_pkg::PH_PRE;
                    pat_tenths = lbec_pkg::LEN_PRE;
                end
            end
            default: begin
                pat_phase  = lbec_pkg::PH_PRE;
                pat_tenths = lbec_pkg::LEN_PRE;
            end
        endcase
    endfunction

    // One tick through the prescaler; zero divider acts as one
    function void tenth_tick();
        logic [16:0] lim;
        lim = (tenth_div == 0) ? 17'd1 : {1'b0, tenth_div};
        pat_presc = pat_presc + 16'd1;
        if ({1'b0, pat_presc} < lim && pat_presc != 0) return;
        pat_presc = 16'd0;
        if (pat_tenths > 0) pat_tenths = pat_tenths - 7'd1;
        if (pat_tenths == 0) close_phase();
    endfunction

    function lbec_pkg::t_result predict_led(input logic req, input logic [31:0] code);
        lbec_pkg::t_result r;
        logic [31:0]       sat;
        if (req == lbec_pkg::REQ_START) begin
            // only the first start latches; later ones are ignored
            if (!pat_active) begin
                sat          = (code > lbec_pkg::CODE_MAX) ? lbec_pkg::CODE_MAX : code;
                pat_digit[0] = 4'(sat / 100);
                pat_digit[1] = 4'((sat % 100) / 10);
                pat_digit[2] = 4'(sat % 10);
                pat_active   = 1'b1;
                pat_phase    = lbec_pkg::PH_PRE;
                pat_tenths   = lbec_pkg::LEN_PRE;
                pat_presc    = 16'd0;
                pat_idx      = 2'd0;
                pat_pulses   = 4'd0;
            end
        end else if (pat_active) begin
            tenth_tick();
        end
        r.led_on    = pat_active &&
                      (pat_phase == lbec_pkg::PH_MARK || pat_phase == lbec_pkg::PH_PHI);
        r.signaling = pat_active;
        return r;
    endfunction

    // Result check, register tracking and prediction on each accepted transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (led_expect_q.size() == 0) begin
                    $error("unexpected result transfer, tdata %h", m_axis_tdata);
                    mismatch_count++;
                end else begin
                    led_exp = led_expect_q.pop_front();
                    if (m_axis_tdata[0] !== led_exp.led_on) begin
                        $error("led_on: expected %0d, got %0d", led_exp.led_on, m_axis_tdata[0]);
                        mismatch_count++;
                    end
                    if (m_axis_tdata[1] !== led_exp.signaling) begin
                        $error("signaling: expected %0d, got %0d",
                               led_exp.signaling, m_axis_tdata[1]);
                        mismatch_count++;
                    end
                    if (m_axis_tdata[7:2] !== 6'd0) begin
                        $error("pad: expected 0, got %0h", m_axis_tdata[7:2]);
                        mismatch_count++;
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) tenth_div = i_cfg_data;
            if (s_axis_tvalid && s_axis_tready)
                led_expect_q.push_back(predict_led(s_axis_tuser[0], s_axis_tdata));
        end
    end

    // Receiver: stall pattern re-picked at random among three modes; long hold-off on request
    always @(negedge i_clk) begin
        rx_cnt++;
        if (rx_cnt % 64 == 0) rx_mode = $urandom_range(0, 2);
        if (hold_req != hold_ack) begin
            hold_ack  = hold_req;
            hold_left = 60;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            case (rx_mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= (rx_cnt % 4 != 0);
                default: m_axis_tready <= 1'($urandom_range(0, 1));
            endcase
        end
    end

    // One input transfer; bursts of random length with gaps between them
    task automatic send_item(input logic req, input logic [31:0] code);
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_axis_tvalid   <= 1'b1;
        s_axis_tdata    <= code;
        s_axis_tuser[0] <= req;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Sender pause until every result is in, plus pipeline latency
    task automatic settle_idle();
        s_axis_tvalid <= 1'b0;
        while (led_expect_q.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_ticks_cfg(input logic [15:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic send_random(input int n_items, input int start_pct);
        for (int i = 0; i < n_items; i++) begin
            if ($urandom_range(0, 99) < start_pct) send_item(lbec_pkg::REQ_START, $urandom());
            else send_item(lbec_pkg::REQ_TICK, $urandom());
        end
    endtask

    // Ticks before any start leave the LED dark
    task automatic test_idle_ticks();
        write_ticks_cfg(16'd1);
        send_item(lbec_pkg::REQ_TICK, 32'h0000_0000);
        send_item(lbec_pkg::REQ_TICK, 32'hFFFF_FFFF);
        send_item(lbec_pkg::REQ_TICK, $urandom());
        settle_idle();
    endtask

    // First start latches the code; repeated starts are ignored
    task automatic test_start_latch();
        logic [31:0] code;
        case ($urandom_range(0, 8))
            0:       code = 32'd0;
            1:       code = 32'd7;
            2:       code = 32'd10;
            3:       code = 32'd100;
            4:       code = 32'd305;
            5:       code = 32'd999;
            6:       code = 32'd1000;
            7:       code = 32'hFFFF_FFFF;
            default: code = $urandom_range(0, 999);
        endcase
        send_item(lbec_pkg::REQ_START, code);
        send_item(lbec_pkg::REQ_START, 32'hFFFF_FFFF);
        send_item(lbec_pkg::REQ_START, 32'd0);
        repeat (8) send_item(lbec_pkg::REQ_TICK, $urandom());
        settle_idle();
    endtask

    // Divider at zero and at its maximum
    task automatic test_prescale_extremes();
        write_ticks_cfg(16'd0);
        repeat (6) send_item(lbec_pkg::REQ_TICK, $urandom());
        settle_idle();
        write_ticks_cfg(16'hFFFF);
        repeat (3) send_item(lbec_pkg::REQ_TICK, $urandom());
        settle_idle();
    endtask

    // Long random tick runs under several divider settings, some with
    // the divider lowered below the running prescale count
    task automatic test_random_ticks();
        int seg_div [8];
        int seg_len [8];
        seg_div = '{1, 2, 3, 2, 0, 65535, 0, 1};
        seg_len = '{260, 40, 30, 20, 20, 20, 20, 40};
        seg_div[4] = $urandom_range(1, 65535);
        for (int s = 0; s < 8; s++) begin
            write_ticks_cfg(16'(seg_div[s]));
            send_random(seg_len[s], 5);
            settle_idle();
        end
    endtask

    // Receiver holds off long enough that the block stalls its input
    task automatic test_backpressure();
        write_ticks_cfg(16'd1);
        hold_req++;
        send_random(40, 5);
        settle_idle();
    endtask

    // Test sequence
    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_idle_ticks();
        test_start_latch();
        test_prescale_extremes();
        test_random_ticks();
        test_backpressure();
        settle_idle();
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
